### design/bcc_pkg.sv
// Shared types, constants and helpers of the backup chunk carver.
package bcc_pkg;

	localparam int TAG_BYTES   = 9;
	localparam int MAGIC_BYTES = 8;
	localparam int POS_W       = 48;
	localparam int LEN_W       = 40;
	localparam int MIN_W       = 16;
	localparam int RAW_W       = POS_W + 2;

	localparam logic [POS_W-1:0] POS_MAX   = {POS_W{1'b1}};
	localparam logic [LEN_W-1:0] LEN_MAX   = {LEN_W{1'b1}};
	localparam logic [LEN_W-1:0] MAX_RESET = 40'd629145600;
	localparam logic [MIN_W-1:0] MIN_RESET = 16'd32;

	localparam logic REG_MAX_FILE = 1'b0;
	localparam logic REG_MIN_FILE = 1'b1;

	localparam logic [7:0] TAG_PATTERN [TAG_BYTES] = '{
		8'h64, 8'h75, 8'h70, 8'h6c, 8'h69, 8'h63, 8'h61, 8'h63, 8'h79
	};
	localparam logic [7:0] MAGIC_PATTERN [MAGIC_BYTES] = '{
		8'h00, 8'h00, 8'h00, 8'h00, 8'h63, 8'h00, 8'h01, 8'h00
	};

	typedef enum logic [2:0] {
		EV_START      = 3'd0,
		EV_END_FOOTER = 3'd1,
		EV_END_HEADER = 3'd2,
		EV_END_LIMIT  = 3'd3,
		EV_TOO_SMALL  = 3'd4
	} event_kind_t;

	typedef struct packed {
		event_kind_t       kind;
		logic [POS_W-1:0]  offset;
		logic [LEN_W-1:0]  length;
		logic              last;
	} event_t;

	function automatic logic [LEN_W-1:0] sat_len(input logic [RAW_W-1:0] v);
		return (|v[RAW_W-1:LEN_W]) ? LEN_MAX : v[LEN_W-1:0];
	endfunction

endpackage

### design/backup_chunk_carver_core.sv
// Top level of the backup chunk carver: byte window, header/footer match and event queue.
//
// One stream byte is taken per transfer, and a byte can be taken in every clock cycle.
// Header and magic matching are parallel compares on the shifted byte window, and all
// offsets, lengths and limit checks are worked out in the same cycle the byte is taken;
// the events it causes (none, one or two) go into a three-entry queue that feeds the
// result port. in_stall rises while two or more events wait, so a byte is taken every
// cycle as long as the result side keeps up, except that a byte that causes two events
// holds the input while the second event drains. Registers: max_file_bytes at byte
// address 0, min_file_bytes at byte address 8; pready is always high.
module backup_chunk_carver_core #(
	parameter int GAP_BYTES   = 5,
	parameter int TRAIL_BYTES = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  event_kind,
	output logic [47:0] file_offset,
	output logic [39:0] file_length,
	output logic        last_event
);
	import bcc_pkg::*;

	localparam int WIN_BYTES  = TAG_BYTES + GAP_BYTES + MAGIC_BYTES;
	localparam int MAGIC_BASE = TAG_BYTES + GAP_BYTES;
	localparam int Q_DEPTH    = 3;

	logic [LEN_W-1:0] max_q;
	logic [MIN_W-1:0] min_q;
	logic [7:0]       window_q [WIN_BYTES];
	logic [7:0]       win_d    [WIN_BYTES];
	logic [POS_W-1:0] pos_q;
	logic             open_q;
	logic [POS_W-1:0] start_q;

	logic             accept, pop;
	logic             magic_hit, tag_hit;
	logic [POS_W-1:0] hdr_start;
	logic [RAW_W-1:0] seen, footer_raw, header_raw, size_raw;
	logic [LEN_W-1:0] footer_len, header_len, size_len;
	logic             open_d;
	logic [POS_W-1:0] start_d;
	logic [1:0]       push_n;
	event_t           ev0, ev1;

	event_t           queue_q [Q_DEPTH];
	logic [1:0]       wr_q, rd_q, cnt_q;
	event_t           head;

	function automatic logic [1:0] ptr_inc(input logic [1:0] p);
		return (p == 2'(Q_DEPTH - 1)) ? 2'd0 : p + 2'd1;
	endfunction

	function automatic event_kind_t end_kind(input event_kind_t k, input logic [LEN_W-1:0] len,
			input logic [MIN_W-1:0] min_len);
		return (len < {{(LEN_W-MIN_W){1'b0}}, min_len}) ? EV_TOO_SMALL : k;
	endfunction

	// configuration port
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= MAX_RESET;
			min_q <= MIN_RESET;
		end else if (psel && penable && pwrite) begin
			case (paddr[3])
				REG_MAX_FILE: max_q <= pwdata[LEN_W-1:0];
				REG_MIN_FILE: min_q <= pwdata[MIN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3])
			REG_MAX_FILE: prdata = {{(64-LEN_W){1'b0}}, max_q};
			REG_MIN_FILE: prdata = {{(64-MIN_W){1'b0}}, min_q};
			default:      prdata = '0;
		endcase
	end

	// match and event generation
	assign in_stall = (cnt_q >= 2'd2);
	assign accept   = in_valid && !in_stall;

	always_comb begin
		for (int i = 0; i < WIN_BYTES - 1; i++) begin
			win_d[i] = window_q[i+1];
		end
		win_d[WIN_BYTES-1] = data_byte;

		magic_hit = (pos_q >= POS_W'(MAGIC_BYTES - 1));
		for (int j = 0; j < MAGIC_BYTES; j++) begin
			if (win_d[MAGIC_BASE+j] != MAGIC_PATTERN[j]) magic_hit = 1'b0;
		end
		tag_hit = (pos_q >= POS_W'(WIN_BYTES - 1));
		for (int j = 0; j < TAG_BYTES; j++) begin
			if (win_d[j] != TAG_PATTERN[j]) tag_hit = 1'b0;
		end
	end

	assign seen       = {2'b00, pos_q} + RAW_W'(1);
	assign hdr_start  = (pos_q >= POS_W'(WIN_BYTES - 1)) ? pos_q - POS_W'(WIN_BYTES - 1) : '0;
	assign footer_raw = seen + RAW_W'(TRAIL_BYTES) - {2'b00, start_q};
	assign header_raw = (hdr_start >= start_q) ? {2'b00, hdr_start - start_q} : '0;
	assign size_raw   = seen - {2'b00, start_q};
	assign footer_len = sat_len(footer_raw);
	assign header_len = sat_len(header_raw);
	assign size_len   = sat_len(size_raw);

	always_comb begin
		open_d  = open_q;
		start_d = start_q;
		push_n  = 2'd0;
		ev0     = '{kind: EV_START, offset: hdr_start, length: '0, last: 1'b1};
		ev1     = '{kind: EV_START, offset: hdr_start, length: '0, last: 1'b1};
		if (!open_q) begin
			if (magic_hit && tag_hit) begin
				open_d  = 1'b1;
				start_d = hdr_start;
				push_n  = 2'd1;
			end
		end else if (magic_hit) begin
			if (tag_hit) begin
				ev0 = '{kind: end_kind(EV_END_HEADER, header_len, min_q), offset: start_q,
					length: header_len, last: 1'b0};
				start_d = hdr_start;
				push_n  = 2'd2;
			end else begin
				ev0 = '{kind: end_kind(EV_END_FOOTER, footer_len, min_q), offset: start_q,
					length: footer_len, last: 1'b1};
				open_d = 1'b0;
				push_n = 2'd1;
			end
		end else if (size_raw >= {{(RAW_W-LEN_W){1'b0}}, max_q}) begin
			ev0 = '{kind: end_kind(EV_END_LIMIT, size_len, min_q), offset: start_q,
				length: size_len, last: 1'b1};
			open_d = 1'b0;
			push_n = 2'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WIN_BYTES; i++) begin
				window_q[i] <= '0;
			end
			pos_q   <= '0;
			open_q  <= 1'b0;
			start_q <= '0;
		end else if (accept) begin
			for (int i = 0; i < WIN_BYTES; i++) begin
				window_q[i] <= win_d[i];
			end
			if (pos_q != POS_MAX) pos_q <= pos_q + POS_W'(1);
			open_q  <= open_d;
			start_q <= start_d;
		end
	end

	// event queue
	assign pop = out_valid && !out_stall;

	always_ff @(posedge clk) begin
		if (accept) begin
			if (push_n != 2'd0) queue_q[wr_q] <= ev0;
			if (push_n == 2'd2) queue_q[ptr_inc(wr_q)] <= ev1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (accept) begin
				case (push_n)
					2'd1:    wr_q <= ptr_inc(wr_q);
					2'd2:    wr_q <= ptr_inc(ptr_inc(wr_q));
					default: ;
				endcase
			end
			if (pop) rd_q <= ptr_inc(rd_q);
			cnt_q <= cnt_q + (accept ? push_n : 2'd0) - {1'b0, pop};
		end
	end

	assign head        = queue_q[rd_q];
	assign out_valid   = (cnt_q != 2'd0);
	assign event_kind  = head.kind;
	assign file_offset = head.offset;
	assign file_length = head.length;
	assign last_event  = head.last;

endmodule

### verif/bcc_checker.sv
// Event checker for the backup chunk carver: tracks registers, predicts events, compares them.
`timescale 1ns / 1ps
module bcc_checker #(
	parameter int GAP_BYTES   = 5,
	parameter int TRAIL_BYTES = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic        pready,
	input  logic [3:0]  paddr,
	input  logic [63:0] pwdata,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [2:0]  event_kind,
	input  logic [47:0] file_offset,
	input  logic [39:0] file_length,
	input  logic        last_event,
	output int          errors,
	output int          pending
);
	import bcc_pkg::*;

	localparam int WIN_BYTES = TAG_BYTES + GAP_BYTES + MAGIC_BYTES;

	logic [7:0]       win_q [WIN_BYTES];
	logic [63:0]      pos_q;
	logic [63:0]      start_q;
	logic             open_q;
	logic [LEN_W-1:0] max_q;
	logic [MIN_W-1:0] min_q;
	event_t           expected_events [$];
	event_t           want;
	int               err_cnt;

	function automatic event_t end_event(event_kind_t k, logic [63:0] off, logic [63:0] raw);
		event_t      e;
		logic [63:0] l;
		l = (raw > LEN_MAX) ? {24'd0, LEN_MAX} : raw;
		e.kind   = (l < min_q) ? EV_TOO_SMALL : k;
		e.offset = off[POS_W-1:0];
		e.length = l[LEN_W-1:0];
		e.last   = 1'b0;
		return e;
	endfunction

	task automatic carve_byte(input logic [7:0] b);
		logic [63:0] seen;
		logic [63:0] hdr;
		logic        magic_hit;
		logic        tag_hit;
		logic        was_open;
		logic        ended;
		event_t      got [$];
		seen = pos_q + 64'd1;
		for (int i = 0; i < WIN_BYTES - 1; i++)
			win_q[i] = win_q[i+1];
		win_q[WIN_BYTES-1] = b;
		if (pos_q < POS_MAX)
			pos_q = pos_q + 64'd1;
		magic_hit = (seen >= MAGIC_BYTES);
		for (int i = 0; i < MAGIC_BYTES; i++)
			if (win_q[TAG_BYTES+GAP_BYTES+i] != MAGIC_PATTERN[i])
				magic_hit = 1'b0;
		tag_hit = (seen >= WIN_BYTES);
		for (int i = 0; i < TAG_BYTES; i++)
			if (win_q[i] != TAG_PATTERN[i])
				tag_hit = 1'b0;
		hdr = (seen >= WIN_BYTES) ? seen - WIN_BYTES : 64'd0;
		was_open = open_q;
		ended = 1'b0;
		if (!open_q) begin
			if (magic_hit && tag_hit) begin
				open_q = 1'b1;
				start_q = hdr;
				got.push_back(event_t'{EV_START, hdr[POS_W-1:0], '0, 1'b0});
			end
		end else if (magic_hit) begin
			ended = 1'b1;
			if (tag_hit) begin
				got.push_back(end_event(EV_END_HEADER, start_q,
					(hdr >= start_q) ? hdr - start_q : 64'd0));
				start_q = hdr;
				got.push_back(event_t'{EV_START, hdr[POS_W-1:0], '0, 1'b0});
			end else begin
				got.push_back(end_event(EV_END_FOOTER, start_q, seen + TRAIL_BYTES - start_q));
				open_q = 1'b0;
			end
		end
		if (was_open && !ended && open_q && (seen - start_q >= max_q)) begin
			got.push_back(end_event(EV_END_LIMIT, start_q, seen - start_q));
			open_q = 1'b0;
		end
		if (got.size() > 0)
			got[got.size()-1].last = 1'b1;
		foreach (got[i])
			expected_events.push_back(got[i]);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (win_q[i])
				win_q[i] = 8'd0;
			pos_q = '0;
			start_q = '0;
			open_q = 1'b0;
			max_q = MAX_RESET;
			min_q = MIN_RESET;
			expected_events.delete();
			err_cnt = 0;
			errors <= 0;
			pending <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				if (paddr == {REG_MAX_FILE, 3'b000})
					max_q = pwdata[LEN_W-1:0];
				else if (paddr == {REG_MIN_FILE, 3'b000})
					min_q = pwdata[MIN_W-1:0];
			end
			if (in_valid && !in_stall)
				carve_byte(data_byte);
			if (out_valid && !out_stall) begin
				if (expected_events.size() == 0) begin
					err_cnt++;
					if (err_cnt <= 10)
						$display("unexpected event: kind %0d offset %0d length %0d last %0d",
							event_kind, file_offset, file_length, last_event);
				end else begin
					want = expected_events.pop_front();
					if (want.kind !== event_kind || want.offset !== file_offset ||
							want.length !== file_length || want.last !== last_event) begin
						err_cnt++;
						if (err_cnt <= 10)
							$display({"event mismatch: expected kind %0d offset %0d length %0d ",
								"last %0d, got kind %0d offset %0d length %0d last %0d"},
								want.kind, want.offset, want.length, want.last,
								event_kind, file_offset, file_length, last_event);
					end
				end
			end
			errors <= err_cnt;
			pending <= expected_events.size();
		end
	end

endmodule

### verif/tb.sv
// Testbench top for the backup chunk carver: clock, reset, byte stimulus, register writes, verdict.
`timescale 1ns / 1ps
module tb;
	import bcc_pkg::*;

	localparam int GAP_LEN     = 5;
	localparam int TRAIL_LEN   = 2;
	localparam int WATCHDOG    = 4000;
	localparam int PHASE_BYTES = 215;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [63:0] pwdata;
	logic [63:0] prdata;
	logic        pready;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  data_byte;
	logic        out_valid;
	logic        out_stall;
	logic [2:0]  event_kind;
	logic [47:0] file_offset;
	logic [39:0] file_length;
	logic        last_event;

	int errors;
	int pending;
	int sent;
	int idle_cycles;
	int gap_mode;
	int stall_mode;
	int stall_hold;

	backup_chunk_carver_core #(
		.GAP_BYTES(GAP_LEN),
		.TRAIL_BYTES(TRAIL_LEN)
	) uut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_stall(in_stall), .data_byte(data_byte),
		.out_valid(out_valid), .out_stall(out_stall), .event_kind(event_kind),
		.file_offset(file_offset), .file_length(file_length), .last_event(last_event)
	);

	bcc_checker #(
		.GAP_BYTES(GAP_LEN),
		.TRAIL_BYTES(TRAIL_LEN)
	) chk (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
		.paddr(paddr), .pwdata(pwdata),
		.in_valid(in_valid), .in_stall(in_stall), .data_byte(data_byte),
		.out_valid(out_valid), .out_stall(out_stall), .event_kind(event_kind),
		.file_offset(file_offset), .file_length(file_length), .last_event(last_event),
		.errors(errors), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin : stall_gen
		int r;
		if (stall_mode == 0) begin
			out_stall <= 1'b0;
		end else if (stall_hold > 0) begin
			stall_hold--;
		end else begin
			r = $urandom_range(99);
			if (r < 60) begin
				out_stall <= 1'b0;
				stall_hold = $urandom_range(2);
			end else if (r < 95) begin
				out_stall <= 1'b1;
				stall_hold = $urandom_range(3);
			end else begin
				out_stall <= 1'b1;
				stall_hold = $urandom_range(10, 40);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG) begin
			$display("FAIL");
			$finish;
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(99);
		if (gap_mode == 0 || r < 70)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic [7:0] rand_byte();
		int r;
		r = $urandom_range(99);
		if (r < 10)
			return 8'h00;
		if (r < 20)
			return 8'hFF;
		return 8'($urandom_range(255));
	endfunction

	function automatic int fill_len();
		if ($urandom_range(99) < 85)
			return $urandom_range(12);
		return $urandom_range(20, 90);
	endfunction

	task automatic send(input logic [7:0] b);
		int g;
		g = pick_gap();
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sent++;
	endtask

	task automatic send_fill(input int n);
		repeat (n) send(rand_byte());
	endtask

	task automatic send_magic(input int n);
		for (int i = 0; i < n; i++)
			send(MAGIC_PATTERN[i]);
	endtask

	task automatic send_tag(input int n);
		for (int i = 0; i < n; i++)
			send(TAG_PATTERN[i]);
	endtask

	task automatic send_header(input int gap);
		send_tag(TAG_BYTES);
		send_fill(gap);
		send_magic(MAGIC_BYTES);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic reg_write(input logic idx, input logic [63:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 3'b000};
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic run_phase(input int nbytes);
		int  first;
		int  r;
		bit  paused;
		first = sent;
		paused = 1'b0;
		while (sent - first < nbytes) begin
			if (!paused && sent - first > nbytes / 2) begin
				drain();
				paused = 1'b1;
			end
			r = $urandom_range(99);
			if (r < 30) begin
				send_header(GAP_LEN);
			end else if (r < 50) begin
				send_magic(MAGIC_BYTES);
				send_fill(TRAIL_LEN);
			end else if (r < 78) begin
				send_fill(fill_len());
			end else if (r < 86) begin
				send_header($urandom_range(1) ? GAP_LEN - 1 : GAP_LEN + 1);
			end else if (r < 93) begin
				send_tag($urandom_range(1, TAG_BYTES - 1));
				send_fill(1);
			end else begin
				send_magic($urandom_range(1, MAGIC_BYTES - 1));
				send(8'hFF);
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		data_byte = '0;
		out_stall = 1'b0;
		sent = 0;
		idle_cycles = 0;
		stall_hold = 0;
		gap_mode = 1;
		stall_mode = 1;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// magic tail against the reset fill, then a header and a plain footer
		send(8'h63);
		send(8'h00);
		send(8'h01);
		send(8'h00);
		send_header(GAP_LEN);
		send_magic(MAGIC_BYTES);
		run_phase(PHASE_BYTES);

		drain();
		reg_write(REG_MAX_FILE, 64'd32);
		reg_write(REG_MIN_FILE, 64'd1);
		gap_mode = 0;
		stall_mode = 0;
		run_phase(PHASE_BYTES);

		drain();
		reg_write(REG_MAX_FILE, {64{1'b1}});
		reg_write(REG_MIN_FILE, {64{1'b1}});
		gap_mode = 1;
		stall_mode = 1;
		run_phase(PHASE_BYTES);

		drain();
		reg_write(REG_MAX_FILE, 64'($urandom_range(33, 150)));
		reg_write(REG_MIN_FILE, 64'($urandom_range(2, 64)));
		gap_mode = 1;
		stall_mode = 0;
		run_phase(PHASE_BYTES);

		drain();
		reg_write(REG_MAX_FILE, 64'($urandom_range(200, 2000)));
		reg_write(REG_MIN_FILE, 64'($urandom_range(1, 300)));
		gap_mode = 0;
		stall_mode = 1;
		run_phase(PHASE_BYTES);

		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
